// File: rtl/lcl_pkg.sv
// Package for the line/column locator: field widths, command and status codes.
// Used by line_column_locator_unit; depends on nothing else.

package lcl_pkg;

    // Default table depth
    localparam int MAX_LINES_DEF = 1024;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int LINE_W   = 11;
    localparam int COL_W    = 33;
    localparam int START_W  = 32;
    localparam int STATUS_W = 2;

    // Packed result width and its byte-padded width
    localparam int RES_W   = LINE_W + COL_W + START_W;
    localparam int RES_PAD = ((RES_W + 7) / 8) * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

// File: rtl/line_column_locator_unit.sv
// Line/column locator: a table of line start offsets in one synchronous RAM,
// searched by an upper-bound binary search. Depends on lcl_pkg.
// Append, get-line-start of line 1, range errors and unused codes go straight to
//   the result; get-line-start of a later line first reads the table once.
// Locate answers an empty table without a table read, else reads the first and
//   then the last start, and if neither decides runs the binary search with
//   one RAM read per search step. A stalled output holds the result until taken.
// One request is in flight at a time; the next is taken while a result waits.
// Reset (synchronous, active low) clears the entry count, the controller and the
//   result valid flag; the table itself is not cleared.

module line_column_locator_unit #(
    parameter int MAX_LINES = lcl_pkg::MAX_LINES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lcl_pkg::VALUE_W-1:0]     i_s_tdata,  // [31:0] value
    input  logic [lcl_pkg::CMD_W-1:0]       i_s_tuser,  // [1:0] cmd
    // result side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [lcl_pkg::RES_PAD-1:0]     o_m_tdata,  // [10:0] line_number,
                                                        // [43:11] column_number,
                                                        // [75:44] start_offset,
                                                        // [79:76] zero
    output logic [lcl_pkg::STATUS_W-1:0]    o_m_tuser   // [1:0] status
);

    localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int VW = lcl_pkg::VALUE_W;
    localparam int LW = lcl_pkg::LINE_W;
    localparam int KW = lcl_pkg::COL_W;
    localparam int SW = lcl_pkg::START_W;
    localparam int TW = lcl_pkg::STATUS_W;
    localparam int PADW = lcl_pkg::RES_PAD - lcl_pkg::RES_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SRCH,
        S_START,
        S_DONE
    } t_state;

    // Controller registers
    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [VW-1:0]   r_val;
    logic [CW-1:0]   r_lo;
    logic [CW-1:0]   r_hi;
    logic [CW-1:0]   r_mid;
    logic [VW-1:0]   r_cand;

    // Pending result
    logic [LW-1:0]   r_res_line;
    logic [KW-1:0]   r_res_col;
    logic [SW-1:0]   r_res_start;
    logic [TW-1:0]   r_res_status;

    // Output register
    logic            r_out_valid;
    logic [LW-1:0]   r_out_line;
    logic [KW-1:0]   r_out_col;
    logic [SW-1:0]   r_out_start;
    logic [TW-1:0]   r_out_status;

    // Line start table
    logic [VW-1:0]   mem [MAX_LINES];
    logic [VW-1:0]   r_rd_data;

    logic            s_acc;
    logic            wr_en;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   cnt_m1;
    logic [VW-1:0]   start_idx;
    logic            cnt_full;
    logic            out_free;
    logic            gt;
    logic [CW-1:0]   nxt_lo;
    logic [CW-1:0]   nxt_hi;
    logic [CW:0]     nxt_sum;
    logic [CW:0]     init_sum;
    logic [VW-1:0]   nxt_cand;
    logic            range_bad;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign cnt_full   = (r_cnt >= CW'(MAX_LINES));
    assign wr_en      = s_acc && (i_s_tuser == lcl_pkg::CMD_APPEND) && !cnt_full;
    assign cnt_m1     = r_cnt - CW'(1);
    assign start_idx  = i_s_tdata - VW'(2);
    assign out_free   = !r_out_valid || i_m_tready;
    assign range_bad  = (i_s_tdata == '0) ||
                        ({1'b0, i_s_tdata} > ((VW+1)'(r_cnt) + (VW+1)'(1)));

    // One search step: narrow [lo, hi) around the word just read
    always_comb begin
        gt       = (r_rd_data > r_val);
        nxt_lo   = gt ? r_lo : (r_mid + CW'(1));
        nxt_hi   = gt ? r_mid : r_hi;
        nxt_cand = gt ? r_cand : r_rd_data;
        nxt_sum  = {1'b0, nxt_lo} + {1'b0, nxt_hi};
        init_sum = {1'b0, r_cnt};
    end

    // Table read address for the next cycle
    always_comb begin
        case (r_state)
            S_IDLE: begin
                if (i_s_tuser == lcl_pkg::CMD_START) begin
                    rd_addr = start_idx[AW-1:0];
                end else begin
                    rd_addr = '0;
                end
            end
            S_FIRST: rd_addr = cnt_m1[AW-1:0];
            S_LAST:  rd_addr = init_sum[AW:1];
            S_SRCH:  rd_addr = nxt_sum[AW:1];
            default: rd_addr = '0;
        endcase
    end

    // Table RAM: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_cnt[AW-1:0]] <= i_s_tdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Controller and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result loads when the output is free, leaves when taken
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_val       <= i_s_tdata;
                        r_res_start <= '0;
                        case (i_s_tuser)
                            lcl_pkg::CMD_APPEND: begin
                                r_res_line <= '0;
                                r_res_col  <= '0;
                                r_state    <= S_DONE;
                                if (cnt_full) begin
                                    r_res_status <= lcl_pkg::ST_FULL;
                                end else begin
                                    r_res_status <= lcl_pkg::ST_OK;
                                    r_cnt        <= r_cnt + CW'(1);
                                end
                            end
                            lcl_pkg::CMD_LOCATE: begin
                                // empty-table answer; later states overwrite it
                                r_res_status <= lcl_pkg::ST_OK;
                                r_res_line   <= LW'(1);
                                r_res_col    <= KW'(i_s_tdata) + KW'(1);
                                if (r_cnt == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_FIRST;
                                end
                            end
                            lcl_pkg::CMD_START: begin
                                r_res_line <= '0;
                                r_res_col  <= '0;
                                if (range_bad) begin
                                    r_res_status <= lcl_pkg::ST_RANGE;
                                    r_state      <= S_DONE;
                                end else if (i_s_tdata != VW'(1)) begin
                                    r_res_status <= lcl_pkg::ST_OK;
                                    r_state      <= S_START;
                                end else begin
                                    r_res_status <= lcl_pkg::ST_OK;
                                    r_state      <= S_DONE;
                                end
                            end
                            default: begin
                                r_res_line   <= '0;
                                r_res_col    <= '0;
                                r_res_status <= lcl_pkg::ST_OK;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end

                // first stored start is on the read port
                S_FIRST: begin
                    r_cand <= r_rd_data;
                    if (r_val < r_rd_data) begin
                        r_res_line <= LW'(1);
                        r_res_col  <= KW'(r_val) + KW'(1);
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_LAST;
                    end
                end

                // last stored start is on the read port
                S_LAST: begin
                    if (r_val >= r_rd_data) begin
                        r_res_line <= LW'(32'(r_cnt) + 32'd1);
                        r_res_col  <= KW'(r_val - r_rd_data) + KW'(1);
                        r_state    <= S_DONE;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= r_cnt;
                        r_mid   <= init_sum[CW:1];
                        r_state <= S_SRCH;
                    end
                end

                // upper-bound search, one word per cycle
                S_SRCH: begin
                    r_lo   <= nxt_lo;
                    r_hi   <= nxt_hi;
                    r_mid  <= nxt_sum[CW:1];
                    r_cand <= nxt_cand;
                    if (nxt_lo >= nxt_hi) begin
                        if (nxt_hi == '0) begin
                            r_res_line <= LW'(2);
                        end else begin
                            r_res_line <= LW'(32'(nxt_hi) + 32'd1);
                        end
                        r_res_col <= KW'(r_val - nxt_cand) + KW'(1);
                        r_state   <= S_DONE;
                    end
                end

                S_START: begin
                    r_res_start <= r_rd_data;
                    r_state     <= S_DONE;
                end

                // hand the result to the output register
                S_DONE: begin
                    if (out_free) begin
                        r_out_line   <= r_res_line;
                        r_out_col    <= r_res_col;
                        r_out_start  <= r_res_start;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PADW{1'b0}}, r_out_start, r_out_col, r_out_line};
    assign o_m_tuser  = r_out_status;

    // Entry count never passes the table depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_LINES))
        else $error("entry count above table depth");

    // Search window stays non-empty while searching
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo < r_hi))
        else $error("empty search window");

    // An accepted append below depth grows the table by one
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_tuser == lcl_pkg::CMD_APPEND) && !cnt_full)
            |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("append did not advance entry count");

    // A located line never carries an error status
    a_loc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_line != '0)) |-> (r_out_status == lcl_pkg::ST_OK))
        else $error("locate result with error status");

endmodule

// File: test/testbench.sv
// Self-checking testbench for line_column_locator_unit: streams append, locate and
// line-start requests and compares every result against a predictor kept here.
// Depends on lcl_pkg and line_column_locator_unit.
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_DEPTH = lcl_pkg::MAX_LINES_DEF;
    localparam logic [lcl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned RUN_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD = 400;

    // One request and the result it should produce
    typedef struct {
        logic [lcl_pkg::CMD_W-1:0]    cmd;
        logic [lcl_pkg::VALUE_W-1:0]  value;
        logic [lcl_pkg::LINE_W-1:0]   line;
        logic [lcl_pkg::COL_W-1:0]    col;
        logic [lcl_pkg::START_W-1:0]  start;
        logic [lcl_pkg::STATUS_W-1:0] status;
    } t_lookup;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [lcl_pkg::VALUE_W-1:0]    i_s_tdata = '0;   // [31:0] value
    logic [lcl_pkg::CMD_W-1:0]      i_s_tuser = '0;   // [1:0] cmd
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [lcl_pkg::RES_PAD-1:0]    o_m_tdata;        // [10:0] line, [43:11] column,
                                                      // [75:44] start, [79:76] zero
    logic [lcl_pkg::STATUS_W-1:0]   o_m_tuser;        // [1:0] status

    // Predictor state: mirror of the line start table
    logic [lcl_pkg::VALUE_W-1:0]    table_starts [0:TABLE_DEPTH-1];
    int unsigned                    table_count = 0;
    logic [lcl_pkg::VALUE_W-1:0]    rising_tail = 32'd300;
    t_lookup                        pending_lookups [$];
    t_lookup                        sink_want;

    // Run bookkeeping
    int unsigned           cycle_count = 0;
    int unsigned           hold_until = 0;
    int                    stall_left = 0;
    bit                    src_idle_on = 1'b1;
    bit                    sink_idle_on = 1'b1;
    int                    mismatch_count = 0;
    int                    results_checked = 0;
    int                    req_count [4] = '{0, 0, 0, 0};
    int                    full_answers = 0;
    int                    range_answers = 0;

    line_column_locator_unit #(
        .MAX_LINES (TABLE_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Predict the result of one accepted request and update the table mirror
    function automatic t_lookup apply_request(input logic [lcl_pkg::CMD_W-1:0] cmd,
                                              input logic [lcl_pkg::VALUE_W-1:0] val);
        t_lookup     res;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned idx;
        res = '{cmd: cmd, value: val, line: '0, col: '0, start: '0,
                status: lcl_pkg::ST_OK};
        req_count[cmd]++;
        case (cmd)
            lcl_pkg::CMD_APPEND: begin
                if (table_count >= TABLE_DEPTH) begin
                    res.status = lcl_pkg::ST_FULL;
                    full_answers++;
                end else begin
                    table_starts[table_count] = val;
                    table_count++;
                end
            end
            lcl_pkg::CMD_LOCATE: begin
                if (table_count == 0 || val < table_starts[0]) begin
                    res.line = 11'd1;
                    res.col = {1'b0, val} + 33'd1;
                end else begin
                    if (val >= table_starts[table_count-1]) begin
                        idx = table_count - 1;
                    end else begin
                        // upper bound search, then step back one entry
                        lo = 0;
                        hi = table_count;
                        while (lo < hi) begin
                            mid = lo + (hi - lo) / 2;
                            if (table_starts[mid] > val) hi = mid;
                            else lo = mid + 1;
                        end
                        idx = (hi == 0) ? 0 : hi - 1;
                    end
                    res.line = lcl_pkg::LINE_W'(idx + 2);
                    res.col = {1'b0, val - table_starts[idx]} + 33'd1;
                end
            end
            lcl_pkg::CMD_START: begin
                if (val == 0 || longint'(val) > longint'(table_count) + 1) begin
                    res.status = lcl_pkg::ST_RANGE;
                    range_answers++;
                end else if (val != 1) begin
                    res.start = table_starts[val-2];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Offer one request, wait for it to be taken, queue its predicted result
    task automatic send_request(input logic [lcl_pkg::CMD_W-1:0] cmd,
                                input logic [lcl_pkg::VALUE_W-1:0] val);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= val;
        do @(posedge i_clk); while (!o_s_tready);
        pending_lookups.insert(pending_lookups.size(), apply_request(cmd, val));
    endtask

    // Stop offering and let every outstanding result come back
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
    endtask

    // One random request, mostly well formed: rising starts, lookups near stored starts
    task automatic issue_random_request(input int append_pct);
        int                          r;
        int                          k;
        logic [lcl_pkg::VALUE_W-1:0] inc;
        logic [lcl_pkg::VALUE_W-1:0] val;
        r = $urandom_range(0, 99);
        if (r < append_pct) begin
            if ($urandom_range(0, 99) < 2) begin
                val = $urandom();
            end else begin
                inc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1 << 21)
                                                  : $urandom_range(1, 200);
                if (rising_tail <= 32'hFFFF_FFFF - inc) rising_tail = rising_tail + inc;
                val = rising_tail;
            end
            send_request(lcl_pkg::CMD_APPEND, val);
        end else if (r < append_pct + (100 - append_pct) / 2) begin
            r = $urandom_range(0, 99);
            if (table_count == 0 || r < 15) begin
                val = $urandom();
            end else begin
                k = $urandom_range(0, table_count - 1);
                if (r < 40) val = table_starts[k];
                else if (r < 55) val = table_starts[k] - 1;
                else if (r < 65) val = table_starts[0] - $urandom_range(1, 4);
                else val = table_starts[k] + $urandom_range(0, 300);
            end
            send_request(lcl_pkg::CMD_LOCATE, val);
        end else if (r < 97) begin
            r = $urandom_range(0, 99);
            if (r < 80) val = $urandom_range(1, table_count + 1);
            else if (r < 90) val = $urandom_range(0, 1) ? 32'd0 : table_count + 2;
            else val = $urandom();
            send_request(lcl_pkg::CMD_START, val);
        end else begin
            send_request(CMD_UNUSED, $urandom());
        end
    endtask

    // Cycle counter and run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Run limit of %0d cycles reached", RUN_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check each accepted result, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: tdata %h status %0d",
                                          o_m_tdata, o_m_tuser));
            end else begin
                sink_want = pending_lookups.pop_front();
                results_checked++;
                if (o_m_tdata[10:0] !== sink_want.line || o_m_tdata[43:11] !== sink_want.col ||
                    o_m_tdata[75:44] !== sink_want.start || o_m_tuser !== sink_want.status) begin
                    report_mismatch($sformatf(
                        "cmd %0d value %h: line %0d/%0d col %0d/%0d start %h/%h status %0d/%0d",
                        sink_want.cmd, sink_want.value, o_m_tdata[10:0], sink_want.line,
                        o_m_tdata[43:11], sink_want.col, o_m_tdata[75:44], sink_want.start,
                        o_m_tuser, sink_want.status));
                end
            end
        end
        if (cycle_count < hold_until) begin
            i_m_tready <= 1'b0;
        end else begin
            if (stall_left == 0 && sink_idle_on) stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Lookups on an empty table: line 1 everywhere, only line 1 has a start
    task automatic test_empty_table();
        send_request(lcl_pkg::CMD_LOCATE, 32'd0);
        send_request(lcl_pkg::CMD_LOCATE, 32'hFFFF_FFFF);
        send_request(lcl_pkg::CMD_LOCATE, 32'd12345);
        send_request(lcl_pkg::CMD_START, 32'd0);
        send_request(lcl_pkg::CMD_START, 32'd1);
        send_request(lcl_pkg::CMD_START, 32'd2);
        send_request(lcl_pkg::CMD_START, 32'hFFFF_FFFF);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF);
    endtask

    // Three starts: before first, on first, between, on and after the last
    task automatic test_small_table();
        send_request(lcl_pkg::CMD_APPEND, 32'd100);
        send_request(lcl_pkg::CMD_LOCATE, 32'd100);
        send_request(lcl_pkg::CMD_APPEND, 32'd200);
        send_request(lcl_pkg::CMD_APPEND, 32'd300);
        send_request(lcl_pkg::CMD_LOCATE, 32'd99);
        send_request(lcl_pkg::CMD_LOCATE, 32'd150);
        send_request(lcl_pkg::CMD_LOCATE, 32'd200);
        send_request(lcl_pkg::CMD_LOCATE, 32'd299);
        send_request(lcl_pkg::CMD_LOCATE, 32'd300);
        send_request(lcl_pkg::CMD_LOCATE, 32'hFFFF_FFFF);
        send_request(lcl_pkg::CMD_START, 32'd1);
        send_request(lcl_pkg::CMD_START, 32'd2);
        send_request(lcl_pkg::CMD_START, 32'd4);
        send_request(lcl_pkg::CMD_START, 32'd5);
        send_request(CMD_UNUSED, 32'd0);
        wait_for_results();
    endtask

    // Results held off for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        hold_until <= cycle_count + LONG_HOLD;
        src_idle_on = 1'b0;
        repeat (30) issue_random_request(50);
        wait_for_results();
        src_idle_on = 1'b1;
    endtask

    // Bulk random traffic, idling pattern changed every so often
    task automatic test_random_mix(input int n_items);
        int mode;
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 0) begin
                mode = (i == 0) ? 3 : $urandom_range(0, 3);
                src_idle_on = mode[0];
                sink_idle_on <= mode[1];
            end
            issue_random_request(70);
        end
        sink_idle_on <= 1'b1;
        src_idle_on = 1'b1;
    endtask

    // Fill the table, last start at the top offset, then run against a full table
    task automatic test_table_full();
        while (table_count < TABLE_DEPTH - 1) issue_random_request(85);
        send_request(lcl_pkg::CMD_APPEND, 32'hFFFF_FFFF);
        send_request(lcl_pkg::CMD_APPEND, 32'd5);
        send_request(lcl_pkg::CMD_APPEND, 32'hFFFF_FFFF);
        send_request(lcl_pkg::CMD_LOCATE, 32'hFFFF_FFFF);
        send_request(lcl_pkg::CMD_LOCATE, 32'hFFFF_FFFE);
        send_request(lcl_pkg::CMD_START, TABLE_DEPTH + 1);
        send_request(lcl_pkg::CMD_START, TABLE_DEPTH + 2);
        send_request(lcl_pkg::CMD_START, TABLE_DEPTH);
        repeat (60) issue_random_request(20);
        wait_for_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_small_table();
        test_result_backpressure();
        test_random_mix(400);
        test_table_full();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_lookups.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_lookups.size()));

        $display("Sent %0d appends, %0d locates, %0d line-start reads, %0d unused codes",
                 req_count[lcl_pkg::CMD_APPEND], req_count[lcl_pkg::CMD_LOCATE],
                 req_count[lcl_pkg::CMD_START], req_count[CMD_UNUSED]);
        $display("Checked %0d results: %0d table-full, %0d out-of-range, %0d mismatches",
                 results_checked, full_answers, range_answers, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lcl_pkg.sv
rtl/line_column_locator_unit.sv
test/testbench.sv
